FILE: design/awr_pkg.sv
// Shared constants and result type for the anemometer window reporter.
package awr_pkg;

  localparam int PERIOD_W        = 8;
  localparam int VANE_W          = 10;
  localparam int SECTOR_W        = 4;
  localparam int OUT_PULSE_W     = 16;
  localparam int PULSE_WIDTH_DEF = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd4;
  localparam logic [PERIOD_W-1:0] EDGE_MAX     = 8'hFF;

  // Half a sector in vane counts; rounds the reading to the nearest sector.
  localparam logic [VANE_W:0]     SECTOR_HALF  = 11'd32;
  // The sector number sits above the 64-count sector step.
  localparam int                  SECTOR_LSB   = 6;

  typedef struct packed {
    logic [OUT_PULSE_W-1:0] window_pulses;
    logic                   speed_report;
    logic [SECTOR_W-1:0]    sector_index;
    logic                   sector_report;
  } result_t;

endpackage

FILE: design/anemometer_window_reporter_core.sv
// Anemometer window reporter: edge counting, window close and report flags.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | request   | in_valid / in_ready  | time_level, wind_level, vane_reading
//  out_    | result    | out_valid / out_ready| window_pulses, speed_report, sector_*
//  cfg_    | write     | cfg_wr_en            | cfg_wr_data -> window length
//
// One request is taken per cycle while in_ready is high; its result (if the timebase
// edge closes a window) goes to the output register, or to the skid register while that one is held.
// A two-entry output buffer (output register plus skid register) keeps
// in_ready high while one result waits; in_ready is a flop output.
// Reset (rst_n low, synchronous) clears all tallies and report history and
// sets the window length to 4.
module anemometer_window_reporter_core #(
  parameter int PULSE_WIDTH = awr_pkg::PULSE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_time_level,
  input  logic                          in_wind_level,
  input  logic [awr_pkg::VANE_W-1:0]    in_vane_reading,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [awr_pkg::OUT_PULSE_W-1:0] out_window_pulses,
  output logic                          out_speed_report,
  output logic [awr_pkg::SECTOR_W-1:0]  out_sector_index,
  output logic                          out_sector_report,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [awr_pkg::PERIOD_W-1:0]  cfg_wr_data
);
  import awr_pkg::*;

  // Width for clipping the tally to the 16-bit result field.
  localparam int CLIP_W = (PULSE_WIDTH > OUT_PULSE_W) ? PULSE_WIDTH : OUT_PULSE_W;
  localparam logic [PULSE_WIDTH-1:0] PULSE_MAX = {PULSE_WIDTH{1'b1}};

  // state
  logic [PERIOD_W-1:0]    win_edges_r;
  logic                   last_time_r;
  logic                   last_wind_r;
  logic [PERIOD_W-1:0]    edge_tally_r;
  logic [PULSE_WIDTH-1:0] pulse_tally_r;
  logic [PULSE_WIDTH-1:0] reported_pulses_r;
  logic                   speed_seen_r;
  logic [SECTOR_W-1:0]    reported_sector_r;
  logic                   sector_seen_r;

  // output buffer
  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_r;
  result_t skid_r;

  // next-state values
  logic [PERIOD_W-1:0]    edge_tally_nxt;
  logic [PULSE_WIDTH-1:0] pulse_tally_nxt;
  logic [PULSE_WIDTH-1:0] reported_pulses_nxt;
  logic                   speed_seen_nxt;
  logic [SECTOR_W-1:0]    reported_sector_nxt;
  logic                   sector_seen_nxt;

  // per-request working signals
  logic                   accept;
  logic                   time_edge;
  logic                   wind_rise;
  logic [PERIOD_W-1:0]    edge_inc;
  logic                   close;
  logic [PULSE_WIDTH-1:0] pulse_base;
  logic [PULSE_WIDTH-1:0] pulse_diff;
  logic                   speed_rep;
  logic [VANE_W:0]        vane_round;
  logic [SECTOR_W-1:0]    sector;
  logic                   sector_rep;
  logic [CLIP_W-1:0]      count_ext;
  result_t                res;
  logic                   produce;
  logic                   out_free;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  // Timebase: every edge counts; a rising edge at or past the period closes.
  always_comb begin
    time_edge = (in_time_level != last_time_r);
    edge_inc  = (edge_tally_r != EDGE_MAX) ? edge_tally_r + 1'b1 : edge_tally_r;
    close     = time_edge && in_time_level && (edge_inc >= win_edges_r);
    if (!time_edge) begin
      edge_tally_nxt = edge_tally_r;
    end else if (close) begin
      edge_tally_nxt = '0;
    end else begin
      edge_tally_nxt = edge_inc;
    end
  end

  // Wind pulses: the close empties the tally first, so a rising edge in
  // the closing sample lands in the new window.
  always_comb begin
    wind_rise  = in_wind_level && !last_wind_r;
    pulse_base = close ? '0 : pulse_tally_r;
    pulse_tally_nxt = (wind_rise && (pulse_base != PULSE_MAX)) ?
                      pulse_base + 1'b1 : pulse_base;
  end

  // Speed deadband: 1 m/s is exactly one window length in pulses.
  always_comb begin
    pulse_diff = (pulse_tally_r >= reported_pulses_r) ?
                 pulse_tally_r - reported_pulses_r :
                 reported_pulses_r - pulse_tally_r;
    speed_rep  = !speed_seen_r ||
                 (pulse_diff >= PULSE_WIDTH'(win_edges_r));
    reported_pulses_nxt = (close && speed_rep) ? pulse_tally_r : reported_pulses_r;
    speed_seen_nxt      = speed_seen_r || (close && speed_rep);
  end

  // Vane: round to nearest 64-count sector; 16 wraps to north.
  always_comb begin
    vane_round = {1'b0, in_vane_reading} + SECTOR_HALF;
    sector     = vane_round[SECTOR_LSB +: SECTOR_W];
    sector_rep = !sector_seen_r || (sector != reported_sector_r);
    reported_sector_nxt = (close && sector_rep) ? sector : reported_sector_r;
    sector_seen_nxt     = sector_seen_r || (close && sector_rep);
  end

  // Result word, tally clipped to the 16-bit field.
  always_comb begin
    count_ext         = CLIP_W'(pulse_tally_r);
    res.window_pulses = (count_ext > CLIP_W'({OUT_PULSE_W{1'b1}})) ?
                        {OUT_PULSE_W{1'b1}} : count_ext[OUT_PULSE_W-1:0];
    res.speed_report  = speed_rep;
    res.sector_index  = sector;
    res.sector_report = sector_rep;
  end

  assign produce  = accept && close;
  assign out_free = !out_valid_r || out_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_edges_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      win_edges_r <= cfg_wr_data;
    end
  end

  // Measurement state, advanced once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r       <= 1'b0;
      last_wind_r       <= 1'b0;
      edge_tally_r      <= '0;
      pulse_tally_r     <= '0;
      reported_pulses_r <= '0;
      speed_seen_r      <= 1'b0;
      reported_sector_r <= '0;
      sector_seen_r     <= 1'b0;
    end else if (accept) begin
      last_time_r       <= in_time_level;
      last_wind_r       <= in_wind_level;
      edge_tally_r      <= edge_tally_nxt;
      pulse_tally_r     <= pulse_tally_nxt;
      reported_pulses_r <= reported_pulses_nxt;
      speed_seen_r      <= speed_seen_nxt;
      reported_sector_r <= reported_sector_nxt;
      sector_seen_r     <= sector_seen_nxt;
    end
  end

  // Output register with skid entry behind it; results leave in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= produce;
      end else begin
        out_valid_r  <= produce;
      end
    end else if (produce) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else if (produce) begin
        out_r <= res;
      end
    end else if (produce) begin
      skid_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_window_pulses = out_r.window_pulses;
  assign out_speed_report  = out_r.speed_report;
  assign out_sector_index  = out_r.sector_index;
  assign out_sector_report = out_r.sector_report;

  // The skid entry only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // A window close restarts the timebase edge count.
  a_close_clears_edges: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> (edge_tally_r == '0))
    else $error("edge tally not cleared after window close");

  // The first closed window always reports speed and sector.
  a_first_report: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && !speed_seen_r && !sector_seen_r) |-> (speed_rep && sector_rep))
    else $error("first window not flagged for report");

endmodule
